@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the player top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/core/isp_pkg.sv @@
// Package with constants, command, mode and register codes and the Gaussian tables of the sample player.
package isp_pkg;
  localparam int unsigned SampleDepth  = 16384;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned GaussEntries = 256;
  localparam int unsigned SampleW      = 16;
  localparam int unsigned AddrW        = 14;
  localparam int unsigned StepW        = 20;
  localparam int unsigned LenW         = 15;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 20;
  localparam logic [15:0] RampFactor   = 16'd65470;
  localparam logic [16:0] StopLevel    = 17'd65;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0, CMD_START = 2'd1, CMD_RAMP = 2'd2, CMD_TICK = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_NEAREST = 2'd0, MODE_LINEAR = 2'd1, MODE_CUBIC = 2'd2, MODE_GAUSS = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE = 3'd0, REG_STEP = 3'd1, REG_LENGTH = 3'd2, REG_START = 3'd3,
    REG_LOOP_EN = 3'd4, REG_LOOP_START = 3'd5, REG_LOOP_END = 3'd6
  } reg_e;

  localparam logic [10:0] GaussOuter [256] = '{
    370,366,362,358,354,351,347,343,339,336,332,328,325,321,318,314,311,307,304,300,
    297,293,290,286,283,280,276,273,270,267,263,260,257,254,251,248,245,242,239,236,
    233,230,227,224,221,218,215,212,210,207,204,201,199,196,193,191,188,186,183,180,
    178,175,173,171,168,166,163,161,159,156,154,152,150,147,145,143,141,139,137,134,
    132,130,128,126,124,122,120,118,117,115,113,111,109,107,106,104,102,100,99,97,
    95,94,92,90,89,87,86,84,83,81,80,78,77,76,74,73,71,70,69,67,
    66,65,64,62,61,60,59,58,56,55,54,53,52,51,50,49,48,47,46,45,
    44,43,42,41,40,39,38,37,36,36,35,34,33,32,32,31,30,29,29,28,
    27,27,26,25,24,24,23,23,22,21,21,20,20,19,19,18,17,17,16,16,
    15,15,15,14,14,13,13,12,12,11,11,11,10,10,10,9,9,9,8,8,
    8,7,7,7,6,6,6,6,5,5,5,5,4,4,4,4,4,3,3,3,
    3,3,2,2,2,2,2,2,2,1,1,1,1,1,1,1,1,1,1,1,
    0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0
  };

  localparam logic [10:0] GaussInner [256] = '{
    1305,1305,1304,1304,1304,1304,1304,1303,1303,1303,1302,1302,1301,1300,1300,1299,
    1298,1297,1297,1296,1295,1294,1293,1292,1291,1290,1288,1287,1286,1284,1283,1282,
    1280,1279,1277,1275,1274,1272,1270,1269,1267,1265,1263,1261,1259,1257,1255,1253,
    1251,1248,1246,1244,1241,1239,1237,1234,1232,1229,1227,1224,1221,1219,1216,1213,
    1210,1207,1205,1202,1199,1196,1193,1190,1186,1183,1180,1177,1174,1170,1167,1164,
    1160,1157,1153,1150,1146,1143,1139,1136,1132,1128,1125,1121,1117,1113,1109,1106,
    1102,1098,1094,1090,1086,1082,1078,1074,1070,1066,1061,1057,1053,1049,1045,1040,
    1036,1032,1027,1023,1019,1014,1010,1005,1001,997,992,988,983,978,974,969,
    965,960,955,951,946,941,937,932,927,923,918,913,908,904,899,894,
    889,884,880,875,870,865,860,855,851,846,841,836,831,826,821,816,
    811,806,802,797,792,787,782,777,772,767,762,757,752,747,742,737,
    732,728,723,718,713,708,703,698,693,688,683,678,674,669,664,659,
    654,649,644,640,635,630,625,620,615,611,606,601,596,592,587,582,
    577,573,568,563,559,554,550,545,540,536,531,527,522,517,513,508,
    504,499,495,491,486,482,477,473,469,464,460,456,451,447,443,439,
    434,430,426,422,418,414,410,405,401,397,393,389,385,381,378,374
  };
endpackage

@@ rtl/core/isp_serial_mul.sv @@
// Shift-and-add signed multiplier: one multiplier bit per cycle.
module isp_serial_mul import isp_pkg::*; #(
  parameter int unsigned AW = 40,
  parameter int unsigned BW = 17,
  parameter int unsigned PW = AW + BW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [AW-1:0] a_i,
  input  logic        [BW-1:0] b_i,
  output logic                 done_o,
  output logic signed [PW-1:0] p_o
);
  localparam int unsigned CntW = $clog2(BW + 1);

  logic signed [PW-1:0] a_q, a_d, p_q, p_d;
  logic        [BW-1:0] b_q, b_d;
  logic        [CntW-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;

  always_comb begin
    a_d = a_q; b_d = b_q; p_d = p_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      a_d = PW'(a_i); b_d = b_i; p_d = '0; cnt_d = CntW'(BW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) p_d = p_q + a_q;
      a_d = a_q <<< 1;
      b_d = b_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; p_q <= p_d;
  end

  assign done_o = done_q;
  assign p_o    = p_q;
endmodule

@@ rtl/core/interpolating_sample_player_top.sv @@
// Top level of the interpolating sample player.
// Usage:
//  - Command channel cmd_valid_i / cmd_stall_o carries command_i, write_address_i and
//    write_sample_i. A transfer happens when valid is high and stall is low.
//  - Write, start and ramp-down commands finish at their transfer edge and give no
//    result. A tick gives one result on out_valid_o / out_stall_i: audio_out_o and
//    is_playing_o.
//  - A playing tick runs every product on one shared shift-and-add multiplier that
//    retires one multiplier bit per cycle: one pass for linear, three for cubic, four
//    for Gaussian, none for nearest, then one for the volume and one more while
//    ramping down. A tick that runs past the end skips the volume passes. A stopped
//    tick answers in the cycle after its transfer.
//  - The sample memory has one write port and one registered read port; a history push reads it once.
//  - One item is in work at a time. The result sits in an output register; the
//    command channel stalls while it is held, and the next command is taken in the
//    cycle after the result transfer.
//  - Reset clears position, volume (unity), flags and history. Sample memory content
//    is undefined until written. Configuration writes (cfg_valid_i / cfg_ready_o,
//    cfg_index_i, cfg_data_i) are always taken, values masked to register widths.
`include "assert_macros.svh"
module interpolating_sample_player_top import isp_pkg::*; #(
  parameter int unsigned SAMPLE_DEPTH = SampleDepth,
  parameter int unsigned FRAC_BITS    = FracBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  output logic                       cmd_stall_o,
  input  logic [1:0]                 command_i,
  input  logic [AddrW-1:0]           write_address_i,
  input  logic signed [SampleW-1:0]  write_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SampleW-1:0]  audio_out_o,
  output logic                       is_playing_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i
);
  localparam int unsigned MemAw = $clog2(SAMPLE_DEPTH);
  localparam int unsigned IntW  = 16;
  localparam int unsigned PosW  = IntW + FRAC_BITS + 1;
  localparam int unsigned MulAw = 40;
  localparam int unsigned MulBw = 17;
  localparam int unsigned MulPw = MulAw + MulBw;

  typedef enum logic [3:0] {
    S_IDLE, S_MEMRD, S_MEMWB, S_M1, S_M2, S_M3, S_M4, S_ADV, S_VOL, S_RAMP, S_OUT
  } state_e;

  // Configuration registers.
  logic [1:0]       mode_q;
  logic [StepW-1:0] step_q;
  logic [LenW-1:0]  len_q;
  logic [AddrW-1:0] startp_q, lstart_q, lend_q;
  logic             loop_en_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_GAUSS; step_q <= StepW'(22861); len_q <= '0;
      startp_q <= '0; loop_en_q <= 1'b0; lstart_q <= '0; lend_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:       mode_q    <= cfg_data_i[1:0];
        REG_STEP:       step_q    <= cfg_data_i[StepW-1:0];
        REG_LENGTH:     len_q     <= cfg_data_i[LenW-1:0];
        REG_START:      startp_q  <= cfg_data_i[AddrW-1:0];
        REG_LOOP_EN:    loop_en_q <= cfg_data_i[0];
        REG_LOOP_START: lstart_q  <= cfg_data_i[AddrW-1:0];
        REG_LOOP_END:   lend_q    <= cfg_data_i[AddrW-1:0];
        default: ;
      endcase
    end
  end

  // Sample memory, one write port and one read port, registered read.
  logic signed [SampleW-1:0] mem [SAMPLE_DEPTH];
  logic signed [SampleW-1:0] rd_q;
  logic                      mem_we;
  logic [MemAw-1:0]          mem_ra;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[MemAw'(write_address_i)] <= write_sample_i;
    rd_q <= mem[mem_ra];
  end

  // Player state.
  state_e                    st_q;
  logic [PosW-1:0]           pos_q, pos_nx_q;
  logic [16:0]               vol_q;
  logic                      ramp_q, play_q;
  logic signed [SampleW-1:0] h_q [4];
  logic signed [MulPw-1:0]   acc_q;
  logic                      push_q;
  logic signed [SampleW-1:0] aout_q;
  logic                      oplay_q, ovalid_q;

  logic                      cmd_xfer;
  assign cmd_stall_o = (st_q != S_IDLE) || ovalid_q;
  assign cmd_xfer    = cmd_valid_i && !cmd_stall_o;
  assign mem_we      = cmd_xfer && (command_i == CMD_WRITE)
                       && (32'(write_address_i) < SAMPLE_DEPTH);

  // Fraction realigned to Q16.
  logic [FRAC_BITS-1:0] frac;
  logic [15:0]          f16;
  logic [7:0]           gr, gm;
  assign frac = pos_q[FRAC_BITS-1:0];
  if (FRAC_BITS >= 16) begin : g_fr_dn
    assign f16 = frac[FRAC_BITS-1 -: 16];
  end else begin : g_fr_up
    assign f16 = {frac, (16-FRAC_BITS)'(0)};
  end
  assign gr = f16[15:8];
  assign gm = 8'd255 - gr;

  logic [IntW:0] ip;  // integer part, extra bit for overflow
  assign ip = pos_q[PosW-1:FRAC_BITS];
  assign mem_ra = MemAw'(ip);

  // Cubic coefficients.
  logic signed [19:0] ca, cb, cc;
  logic signed [19:0] e0, e1, e2, e3;
  assign e0 = 20'(h_q[0]); assign e1 = 20'(h_q[1]);
  assign e2 = 20'(h_q[2]); assign e3 = 20'(h_q[3]);
  assign ca = 20'(3) * (e1 - e2) - e0 + e3;
  assign cb = 20'(4) * e2 + 20'(2) * e0 - 20'(5) * e1 - e3;
  assign cc = e2 - e0;

  // Shared serial multiplier.
  logic                    m_start, m_done;
  logic signed [MulAw-1:0] m_a;
  logic        [MulBw-1:0] m_b;
  logic signed [MulPw-1:0] m_p;

  isp_serial_mul #(.AW(MulAw), .BW(MulBw)) u_mul (
    .clk_i, .rst_ni, .start_i(m_start), .a_i(m_a), .b_i(m_b),
    .done_o(m_done), .p_o(m_p)
  );

  logic m_go_q;  // multiplier launched for current state
  assign m_start = m_go_q;

  // Operand selection per state; acc_q carries the running value.
  logic signed [MulAw-1:0] ga_ops [4];
  logic        [10:0]      gc_ops [4];
  assign ga_ops[0] = MulAw'(h_q[0]); assign gc_ops[0] = GaussOuter[gr];
  assign ga_ops[1] = MulAw'(h_q[1]); assign gc_ops[1] = GaussInner[gr];
  assign ga_ops[2] = MulAw'(h_q[2]); assign gc_ops[2] = GaussInner[gm];
  assign ga_ops[3] = MulAw'(h_q[3]); assign gc_ops[3] = GaussOuter[gm];

  logic [1:0] k_q;  // step index within a mode
  always_comb begin
    m_a = acc_q[MulAw-1:0];
    m_b = {1'b0, f16};
    case (st_q)
      S_M1: begin
        if (mode_q == MODE_GAUSS) begin
          m_a = ga_ops[k_q]; m_b = MulBw'(gc_ops[k_q]);
        end else if (mode_q == MODE_LINEAR) begin
          m_a = MulAw'(e3 - e2);
        end else begin
          m_a = MulAw'(ca);
        end
      end
      S_M2: m_a = acc_q[MulAw-1:0];
      S_VOL: begin
        m_a = acc_q[MulAw-1:0]; m_b = vol_q;
      end
      S_RAMP: begin
        m_a = MulAw'({1'b0, vol_q}); m_b = MulBw'(RampFactor);
      end
      default: ;
    endcase
  end

  // Next position and end test.
  logic [PosW-1:0] step_al, pos_add;
  if (FRAC_BITS >= 16) begin : g_st_up
    assign step_al = PosW'(step_q) << (FRAC_BITS - 16);
  end else begin : g_st_dn
    assign step_al = PosW'(step_q >> (16-FRAC_BITS));
  end
  assign pos_add = pos_q + step_al;

  logic [IntW:0] np;
  assign np = pos_nx_q[PosW-1:FRAC_BITS];

  // Saturate y = floor((v*vol + 2^31) / 2^32).
  logic signed [MulPw-1:0] yr;
  logic signed [MulPw-33:0] ys;
  logic signed [SampleW-1:0] ysat;
  assign yr = m_p + (MulPw'(1) <<< 31);
  assign ys = yr[MulPw-1:32];
  always_comb begin
    if (ys > (MulPw-32)'(32767))       ysat = 16'sh7fff;
    else if (ys < -(MulPw-32)'(32768)) ysat = -16'sh8000;
    else                               ysat = ys[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; pos_q <= '0; pos_nx_q <= '0; vol_q <= 17'd65536;
      ramp_q <= 1'b0; play_q <= 1'b0; ovalid_q <= 1'b0; oplay_q <= 1'b0;
      aout_q <= '0; m_go_q <= 1'b0; k_q <= '0; push_q <= 1'b0; acc_q <= '0;
      for (int i = 0; i < 4; i++) h_q[i] <= '0;
    end else begin
      m_go_q <= 1'b0;
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (cmd_xfer) begin
            case (command_i)
              CMD_START: begin
                for (int i = 0; i < 4; i++) h_q[i] <= '0;
                pos_q  <= PosW'({startp_q, FRAC_BITS'(0)});
                vol_q  <= 17'd65536; ramp_q <= 1'b0; play_q <= 1'b1;
              end
              CMD_RAMP: ramp_q <= 1'b1;
              CMD_TICK: begin
                if (!play_q) begin
                  aout_q <= '0; oplay_q <= 1'b0; ovalid_q <= 1'b1;
                end else begin
                  // Read old-index sample now for a possible push.
                  pos_nx_q <= pos_add;
                  st_q <= S_MEMRD;
                end
              end
              default: ;
            endcase
          end
        end
        S_MEMRD: begin
          st_q <= S_MEMWB;
        end
        S_MEMWB: begin
          push_q <= (np > ip);
          k_q <= '0;
          if (mode_q == MODE_NEAREST) begin
            acc_q <= MulPw'(h_q[3]) <<< 16;
            st_q <= S_ADV;
          end else begin
            acc_q <= '0;
            m_go_q <= 1'b1; st_q <= S_M1;
          end
        end
        S_M1: begin
          if (m_done) begin
            if (mode_q == MODE_GAUSS) begin
              if (k_q == 2'd3) begin
                acc_q <= (acc_q + m_p) <<< 5;
                st_q <= S_ADV;
              end else begin
                acc_q <= acc_q + m_p;
                k_q <= k_q + 1'b1; m_go_q <= 1'b1;
              end
            end else if (mode_q == MODE_LINEAR) begin
              acc_q <= (MulPw'(h_q[2]) <<< 16) + m_p;
              st_q <= S_ADV;
            end else begin
              acc_q <= (m_p >>> 16) + (MulPw'(cb) <<< 16);
              m_go_q <= 1'b1; st_q <= S_M2; k_q <= '0;
            end
          end
        end
        S_M2: begin
          if (m_done) begin
            if (k_q == 2'd0) begin
              acc_q <= (m_p >>> 16) + (MulPw'(cc) <<< 16);
              k_q <= 2'd1; m_go_q <= 1'b1;
            end else begin
              acc_q <= ((m_p >>> 16) + (MulPw'(e1) <<< 17)) >>> 1;
              st_q <= S_ADV;
            end
          end
        end
        S_ADV: begin
          if (np > (IntW+1)'(len_q)) begin
            play_q <= 1'b0; aout_q <= '0; oplay_q <= 1'b0; ovalid_q <= 1'b1;
            pos_q <= pos_nx_q; st_q <= S_IDLE;
          end else begin
            if (push_q) begin
              h_q[0] <= h_q[1]; h_q[1] <= h_q[2]; h_q[2] <= h_q[3];
              h_q[3] <= ((ip < (IntW+1)'(len_q)) && (32'(ip) < SAMPLE_DEPTH))
                        ? rd_q : '0;
            end
            if (loop_en_q && pos_nx_q > PosW'({lend_q, FRAC_BITS'(0)}))
              pos_q <= PosW'({lstart_q, FRAC_BITS'(0)});
            else
              pos_q <= pos_nx_q;
            m_go_q <= 1'b1; st_q <= S_VOL;
          end
        end
        S_VOL: begin
          if (m_done) begin
            aout_q <= ysat;
            if (ramp_q) begin
              m_go_q <= 1'b1; st_q <= S_RAMP;
            end else begin
              oplay_q <= (vol_q > StopLevel); play_q <= (vol_q > StopLevel);
              st_q <= S_OUT;
            end
          end
        end
        S_RAMP: begin
          if (m_done) begin
            vol_q <= m_p[32:16];
            oplay_q <= (m_p[32:16] > StopLevel); play_q <= (m_p[32:16] > StopLevel);
            st_q <= S_OUT;
          end
        end
        S_OUT: begin
          ovalid_q <= 1'b1; st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = ovalid_q;
  assign audio_out_o  = aout_q;
  assign is_playing_o = oplay_q;

  `ASSERT_IMPL(a_stall_busy, clk_i, rst_ni, st_q != S_IDLE, cmd_stall_o)
  `ASSERT_IMPL(a_no_out_busy, clk_i, rst_ni, ovalid_q, st_q == S_IDLE)
  `ASSERT_NEXT(a_stop_zero, clk_i, rst_ni, cmd_xfer && command_i == CMD_TICK && !play_q,
               out_valid_o && audio_out_o == '0 && !is_playing_o)
endmodule
